FILE: rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, constants and beat types of the stereo correlation meter.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int ACC_BITS    = 48;
    localparam int COEFF_BITS  = 24;
    localparam int OUT_BITS    = 16;
    localparam int HALF_BITS   = ACC_BITS / 2;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [COEFF_BITS-1:0] COEFF_RESET = COEFF_BITS'(6990);

    // one stereo sample pair as held in the input queue
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          block_end;
    } item_t;

    // averages handed over for a snapshot, power terms already clamped at zero
    typedef struct packed {
        logic        [ACC_BITS-1:0] ll;
        logic        [ACC_BITS-1:0] rr;
        logic        [ACC_BITS-1:0] mm;
        logic        [ACC_BITS-1:0] ss;
        logic signed [ACC_BITS-1:0] lr;
    } snap_req_t;

    // result beat, correlation in the lowest bits
    typedef struct packed {
        logic signed [OUT_BITS-1:0] balance;
        logic        [OUT_BITS-1:0] stereo_width;
        logic signed [OUT_BITS-1:0] correlation;
    } result_t;

endpackage

FILE: rtl/scm_front.sv
// ----------------------------------------------------------------------------
// scm_front
// Input side: accepts sample beats into a two-entry queue for the averager.
// ----------------------------------------------------------------------------
module scm_front
    import scm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [2*SAMPLE_BITS-1:0]   s_axis_tdata,  // left_sample, right_sample
    input  logic                       s_axis_tlast,  // block_end
    output logic                       item_valid,
    input  logic                       item_ready,
    output item_t                      item
);

    item_t      mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign s_axis_tready = (count_reg != 2'(FIFO_DEPTH));
    assign item_valid    = (count_reg != 2'd0);
    assign item          = mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_valid && item_ready;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{left_sample:  s_axis_tdata[SAMPLE_BITS-1:0],
                                     right_sample: s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
                                     block_end:    s_axis_tlast};
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(FIFO_DEPTH))
        else $error("input queue overfilled");

endmodule

FILE: rtl/scm_ema.sv
// ----------------------------------------------------------------------------
// scm_ema
// Back end per sample: forms the five products and steps the five moving
// averages through one shared 24x24 multiplier.
// ----------------------------------------------------------------------------
module scm_ema
    import scm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COEFF_BITS-1:0] coeff,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  snap_start,
    input  logic                  snap_ready,
    output snap_req_t             snap_req
);

    typedef enum logic [2:0] {S_IDLE, S_PMUL, S_DIFF, S_LMUL, S_HMUL, S_UPD, S_SNAP} state_t;

    state_t                      state_reg;
    logic [2:0]                  k_reg;
    logic [HALF_BITS-1:0]        ml_reg, mr_reg, hs_reg, hd_reg;
    logic                        hs_odd_reg, hd_odd_reg, lr_neg_reg, last_reg;
    logic [ACC_BITS-1:0]         mul_reg;
    logic [ACC_BITS-1:0]         mag_reg;
    logic                        neg_reg;
    logic [HALF_BITS:0]          t_reg;
    logic signed [ACC_BITS-1:0]  acc_reg [5];

    logic [HALF_BITS-1:0]        mul_a, mul_b;
    logic signed [SAMPLE_BITS:0] sum_s, dif_s;
    logic [SAMPLE_BITS:0]        sum_m, dif_m;
    logic [ACC_BITS-1:0]         base;
    logic signed [ACC_BITS:0]    prod_s, diff_s;
    logic [ACC_BITS:0]           diff_m;
    logic [ACC_BITS:0]           round_sum;
    logic [ACC_BITS-1:0]         step;
    logic signed [ACC_BITS-1:0]  acc_k;

    // mid and side magnitudes of the incoming pair
    assign sum_s = {item.left_sample[SAMPLE_BITS-1], item.left_sample}
                 + {item.right_sample[SAMPLE_BITS-1], item.right_sample};
    assign dif_s = {item.left_sample[SAMPLE_BITS-1], item.left_sample}
                 - {item.right_sample[SAMPLE_BITS-1], item.right_sample};
    assign sum_m = sum_s[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-sum_s) : sum_s;
    assign dif_m = dif_s[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dif_s) : dif_s;

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PMUL:
            begin
                case (k_reg)
                    3'd0:    begin mul_a = ml_reg; mul_b = ml_reg; end
                    3'd1:    begin mul_a = mr_reg; mul_b = mr_reg; end
                    3'd2:    begin mul_a = ml_reg; mul_b = mr_reg; end
                    3'd3:    begin mul_a = hs_reg; mul_b = hs_reg; end
                    default: begin mul_a = hd_reg; mul_b = hd_reg; end
                endcase
            end
            S_LMUL:  begin mul_a = mag_reg[HALF_BITS-1:0];        mul_b = coeff; end
            S_HMUL:  begin mul_a = mag_reg[ACC_BITS-1:HALF_BITS]; mul_b = coeff; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // product, difference to the average and rounded step
    assign acc_k = acc_reg[k_reg];
    always_comb
    begin
        base = mul_reg;
        if (k_reg == 3'd3 && hs_odd_reg)
            base = mul_reg + ACC_BITS'(hs_reg);
        else if (k_reg == 3'd4 && hd_odd_reg)
            base = mul_reg + ACC_BITS'(hd_reg);
    end
    assign prod_s    = (k_reg == 3'd2 && lr_neg_reg) ? -$signed({1'b0, base})
                                                     : $signed({1'b0, base});
    assign diff_s    = prod_s - $signed({acc_k[ACC_BITS-1], acc_k});
    assign diff_m    = diff_s[ACC_BITS] ? (ACC_BITS+1)'(-diff_s) : diff_s;
    assign round_sum = {1'b0, mul_reg} + (ACC_BITS+1)'(1 << (COEFF_BITS-1));
    assign step      = mul_reg + ACC_BITS'(t_reg);

    assign item_ready = (state_reg == S_IDLE);
    assign snap_start = (state_reg == S_SNAP) && snap_ready;

    // snapshot values, power averages clamped at zero
    assign snap_req.ll = acc_reg[0][ACC_BITS-1] ? '0 : acc_reg[0];
    assign snap_req.rr = acc_reg[1][ACC_BITS-1] ? '0 : acc_reg[1];
    assign snap_req.lr = acc_reg[2];
    assign snap_req.mm = acc_reg[3][ACC_BITS-1] ? '0 : acc_reg[3];
    assign snap_req.ss = acc_reg[4][ACC_BITS-1] ? '0 : acc_reg[4];

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    // sequencer and averages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            last_reg  <= 1'b0;
            for (int i = 0; i < 5; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        ml_reg     <= item.left_sample[SAMPLE_BITS-1]
                                      ? HALF_BITS'(-item.left_sample) : item.left_sample;
                        mr_reg     <= item.right_sample[SAMPLE_BITS-1]
                                      ? HALF_BITS'(-item.right_sample) : item.right_sample;
                        lr_neg_reg <= item.left_sample[SAMPLE_BITS-1]
                                      ^ item.right_sample[SAMPLE_BITS-1];
                        hs_reg     <= sum_m[SAMPLE_BITS:1];
                        hs_odd_reg <= sum_m[0];
                        hd_reg     <= dif_m[SAMPLE_BITS:1];
                        hd_odd_reg <= dif_m[0];
                        last_reg   <= item.block_end;
                        k_reg      <= '0;
                        state_reg  <= S_PMUL;
                    end
                end
                S_PMUL:
                    state_reg <= S_DIFF;
                S_DIFF:
                begin
                    mag_reg   <= diff_m[ACC_BITS-1:0];
                    neg_reg   <= diff_s[ACC_BITS];
                    state_reg <= S_LMUL;
                end
                S_LMUL:
                    state_reg <= S_HMUL;
                S_HMUL:
                begin
                    t_reg     <= round_sum[ACC_BITS:COEFF_BITS];
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    acc_reg[k_reg] <= neg_reg ? acc_k - $signed(step) : acc_k + $signed(step);
                    if (k_reg == 3'd4)
                        state_reg <= last_reg ? S_SNAP : S_IDLE;
                    else
                    begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_PMUL;
                    end
                end
                S_SNAP:
                begin
                    if (snap_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_lr_power_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg[0][ACC_BITS-1] && !acc_reg[1][ACC_BITS-1])
        else $error("left or right power average went negative");

    a_ms_power_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg[3][ACC_BITS-1] && !acc_reg[4][ACC_BITS-1])
        else $error("mid or side power average went negative");

endmodule

FILE: rtl/scm_snap.sv
// ----------------------------------------------------------------------------
// scm_snap
// Snapshot unit: LL*RR over partial products, bit-pair square root, then
// three restoring fraction divides for correlation, width and balance.
// ----------------------------------------------------------------------------
module scm_snap
    import scm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      snap_start,
    output logic      snap_ready,
    input  snap_req_t snap_req,
    output logic      res_valid,
    input  logic      res_ready,
    output result_t   res
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DSET, S_DIV, S_DEND, S_OUT} state_t;
    typedef enum logic [1:0] {Q_CORR, Q_WIDTH, Q_BAL} quot_t;

    state_t                state_reg;
    quot_t                 sel_reg;
    logic [5:0]            cnt_reg;
    snap_req_t             req_reg;
    logic [HALF_BITS-1:0]  mul_a, mul_b;
    logic [ACC_BITS-1:0]   mul_reg;
    logic [2*ACC_BITS-1:0] prod_reg, prod_next, pp;
    logic [2*ACC_BITS-1:0] rad_reg;
    logic [ACC_BITS:0]     rem_reg;
    logic [ACC_BITS-1:0]   root_reg;
    logic [ACC_BITS+2:0]   rem_sh, trial;
    logic [ACC_BITS:0]     n_sel, d_sel;
    logic                  neg_sel;
    logic [ACC_BITS:0]     d_reg;
    logic [ACC_BITS:0]     drem_reg;
    logic [ACC_BITS+1:0]   drem_sh;
    logic [OUT_BITS:0]     q_reg, qf;
    logic                  dzero_reg, full_reg, neg_reg;
    logic [5:0]            last_step;
    logic [ACC_BITS-1:0]   lr_mag, bal_mag;
    logic [OUT_BITS-1:0]   sq_val;

    assign snap_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);

    // partial product select for LL*RR
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin mul_a = req_reg.ll[HALF_BITS-1:0];        mul_b = req_reg.rr[HALF_BITS-1:0]; end
            2'd1:    begin mul_a = req_reg.ll[HALF_BITS-1:0];        mul_b = req_reg.rr[ACC_BITS-1:HALF_BITS]; end
            2'd2:    begin mul_a = req_reg.ll[ACC_BITS-1:HALF_BITS]; mul_b = req_reg.rr[HALF_BITS-1:0]; end
            default: begin mul_a = req_reg.ll[ACC_BITS-1:HALF_BITS]; mul_b = req_reg.rr[ACC_BITS-1:HALF_BITS]; end
        endcase
    end

    // place the previous partial product
    always_comb
    begin
        case (cnt_reg)
            6'd1:    pp = (2*ACC_BITS)'(mul_reg);
            6'd2:    pp = (2*ACC_BITS)'(mul_reg) << HALF_BITS;
            6'd3:    pp = (2*ACC_BITS)'(mul_reg) << HALF_BITS;
            6'd4:    pp = (2*ACC_BITS)'(mul_reg) << ACC_BITS;
            default: pp = '0;
        endcase
    end
    assign prod_next = prod_reg + pp;

    // square root step: two radicand bits a cycle
    assign rem_sh = {rem_reg, rad_reg[2*ACC_BITS-1:2*ACC_BITS-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // divide operands
    assign lr_mag  = req_reg.lr[ACC_BITS-1] ? ACC_BITS'(-req_reg.lr) : req_reg.lr;
    assign bal_mag = (req_reg.rr >= req_reg.ll) ? req_reg.rr - req_reg.ll
                                                : req_reg.ll - req_reg.rr;
    always_comb
    begin
        case (sel_reg)
            Q_CORR:
            begin
                n_sel   = {1'b0, lr_mag};
                d_sel   = {1'b0, root_reg};
                neg_sel = req_reg.lr[ACC_BITS-1];
            end
            Q_WIDTH:
            begin
                n_sel   = {1'b0, req_reg.ss};
                d_sel   = {1'b0, req_reg.mm} + {1'b0, req_reg.ss};
                neg_sel = 1'b0;
            end
            default:
            begin
                n_sel   = {1'b0, bal_mag};
                d_sel   = {1'b0, req_reg.ll} + {1'b0, req_reg.rr};
                neg_sel = (req_reg.rr < req_reg.ll);
            end
        endcase
    end

    assign last_step = (sel_reg == Q_WIDTH) ? 6'(OUT_BITS - 1) : 6'(OUT_BITS - 2);
    assign drem_sh   = {drem_reg, 1'b0};

    // quotient with the full-scale case, then signed saturation
    always_comb
    begin
        if (full_reg)
            qf = (sel_reg == Q_WIDTH) ? (OUT_BITS+1)'(1) << OUT_BITS
                                      : (OUT_BITS+1)'(1) << (OUT_BITS - 1);
        else
            qf = q_reg;
        if (dzero_reg)
            sq_val = '0;
        else if (neg_reg)
            sq_val = OUT_BITS'(-qf);
        else if (qf >= (OUT_BITS+1)'(1) << (OUT_BITS - 1))
            sq_val = OUT_BITS'((1 << (OUT_BITS - 1)) - 1);
        else
            sq_val = qf[OUT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    // snapshot sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= Q_CORR;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (snap_start)
                    begin
                        req_reg   <= snap_req;
                        prod_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= prod_next;
                    if (cnt_reg == 6'd4)
                    begin
                        rad_reg   <= prod_next;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_SQRT:
                begin
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= (ACC_BITS+1)'(rem_sh - trial);
                        root_reg <= {root_reg[ACC_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[ACC_BITS:0];
                        root_reg <= {root_reg[ACC_BITS-2:0], 1'b0};
                    end
                    rad_reg <= rad_reg << 2;
                    if (cnt_reg == 6'(ACC_BITS - 1))
                    begin
                        sel_reg   <= Q_CORR;
                        state_reg <= S_DSET;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_DSET:
                begin
                    drem_reg  <= n_sel;
                    d_reg     <= d_sel;
                    dzero_reg <= (d_sel == '0);
                    full_reg  <= (n_sel >= d_sel);
                    neg_reg   <= neg_sel;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (drem_sh >= {1'b0, d_reg})
                    begin
                        drem_reg <= (ACC_BITS+1)'(drem_sh - {1'b0, d_reg});
                        q_reg    <= {q_reg[OUT_BITS-1:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= drem_sh[ACC_BITS:0];
                        q_reg    <= {q_reg[OUT_BITS-1:0], 1'b0};
                    end
                    if (cnt_reg == last_step)
                        state_reg <= S_DEND;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_DEND:
                begin
                    case (sel_reg)
                        Q_CORR:
                        begin
                            res.correlation <= sq_val;
                            sel_reg         <= Q_WIDTH;
                            state_reg       <= S_DSET;
                        end
                        Q_WIDTH:
                        begin
                            if (dzero_reg)
                                res.stereo_width <= '0;
                            else if (qf[OUT_BITS])
                                res.stereo_width <= '1;
                            else
                                res.stereo_width <= qf[OUT_BITS-1:0];
                            sel_reg   <= Q_BAL;
                            state_reg <= S_DSET;
                        end
                        default:
                        begin
                            res.balance <= sq_val;
                            state_reg   <= S_OUT;
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("snapshot result changed before it was taken");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        snap_start |=> state_reg == S_MUL)
        else $error("snapshot start not taken");

endmodule

FILE: rtl/stereo_correlation_meter_top.sv
// ----------------------------------------------------------------------------
// stereo_correlation_meter_top
// Stereo phase correlation meter: five moving averages per sample pair and a
// correlation, width and balance snapshot at each block end.
// ----------------------------------------------------------------------------
// the averager steps five averages through one shared multiplier and takes a new sample
//   beat only after all five are updated (and, at a block end, the snapshot has started)
// a block-end beat gives its result after its last average update, through the LL*RR
//   partial products, the square root, the three divides and the output register
// the snapshot unit runs beside the averager; a block end waits while it is busy
// reset: asynchronous active low, averages to zero, coefficient to 6990
module stereo_correlation_meter_top
    import scm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [COEFF_BITS-1:0]     cfg_wr_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [2*SAMPLE_BITS-1:0]  s_axis_tdata,  // left_sample, right_sample
    input  logic                      s_axis_tlast,  // block_end
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [3*OUT_BITS-1:0]     m_axis_tdata   // correlation, stereo_width, balance
);

    logic [COEFF_BITS-1:0] coeff_reg;
    logic                  item_valid, item_ready;
    item_t                 item;
    logic                  snap_start, snap_ready;
    snap_req_t             snap_req;
    logic                  res_valid, res_ready;
    result_t               res;
    logic                  out_valid_reg;
    result_t               out_reg;

    // smoothing coefficient register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coeff_reg <= COEFF_RESET;
        else if (cfg_wr_en)
            coeff_reg <= cfg_wr_data;
    end

    scm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    scm_ema u_ema (
        .clk        (clk),
        .rst_n      (rst_n),
        .coeff      (coeff_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .snap_start (snap_start),
        .snap_ready (snap_ready),
        .snap_req   (snap_req)
    );

    scm_snap u_snap (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_start (snap_start),
        .snap_ready (snap_ready),
        .snap_req   (snap_req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output beat register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule
